>>> sv/sfct_pkg.sv
// ----------------------------------------------------------------------------
// sfct_pkg: definitions for the sorted frame count table
// Sizes, entry layout and index helpers used by the table, also to size its memories.
// ----------------------------------------------------------------------------
package sfct_pkg;

  // Table geometry.
  localparam int unsigned NUM_LABELS = 16;
  localparam int unsigned LIST_SLOTS = 16;
  localparam int unsigned PAIRS      = NUM_LABELS * NUM_LABELS;
  localparam int unsigned ENTRIES    = PAIRS * LIST_SLOTS;

  // Field widths fixed by the interface.
  localparam int unsigned IN_LBL_W  = 4;
  localparam int unsigned CODE_W    = 16;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned OUT_POS_W = 4;

  // Derived widths.
  localparam int unsigned LBL_W  = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
  localparam int unsigned PAIR_W = $clog2(PAIRS);
  localparam int unsigned ENT_W  = $clog2(ENTRIES);
  localparam int unsigned POS_W  = $clog2(LIST_SLOTS);
  localparam int unsigned LEN_W  = $clog2(LIST_SLOTS + 1);

  // One list entry: frame code and its occurrence count.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Reduces a label into the range of the table by repeated subtraction.
  function automatic logic [LBL_W-1:0] reduce_label(logic [IN_LBL_W-1:0] lbl);
    logic [IN_LBL_W-1:0] t;
    t = lbl;
    for (int i = 0; i < 8; i++) begin
      if (int'(t) >= NUM_LABELS) begin
        t = t - IN_LBL_W'(NUM_LABELS);
      end
    end
    return LBL_W'(t);
  endfunction

  // Index of the list pair for a parent and head label.
  function automatic logic [PAIR_W-1:0] pair_index(logic [LBL_W-1:0] p,
                                                   logic [LBL_W-1:0] h);
    return PAIR_W'(int'(p) * NUM_LABELS + int'(h));
  endfunction

  // Address of one slot of a pair's list.
  function automatic logic [ENT_W-1:0] entry_addr(logic [PAIR_W-1:0] pair,
                                                  logic [POS_W-1:0] slot);
    return ENT_W'(int'(pair) * LIST_SLOTS + int'(slot));
  endfunction

endpackage

>>> sv/sfct_ram.sv
// ----------------------------------------------------------------------------
// sfct_ram: simple dual-port memory
// One write port and one read port with a registered read result.
// ----------------------------------------------------------------------------
module sfct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read; a read returns the old contents on a collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sorted_frame_count_table.sv
// ----------------------------------------------------------------------------
// sorted_frame_count_table: per label pair sorted frame code histograms
// Keeps an ascending list of frame codes with counts for each side of each
// parent/head label pair, and updates both lists per transaction; a full list takes no new code.
// ----------------------------------------------------------------------------
// Usage: an input transaction (parent_label_i, head_label_i, left_frame_i,
// right_frame_i) is taken when in_valid_i and in_ready_o are both high. It
// produces exactly one output transaction carrying the count, slot and
// insertion flag of each side plus list_full_o, taken when out_valid_o and
// out_ready_i are both high.
// One sequencer with a single 16-bit compare unit and one saturating
// incrementer treats the left list and then the right list. Each side
// scans its list through the entry memory read port (one slot per cycle)
// and, on an insertion, moves the later entries up one slot per cycle.
// in_ready_o is low while an item is worked on. A finished result sits in
// the output register; the next item is accepted while it waits, and only
// the hand-over of the following result waits for out_ready_i.
// After reset the list lengths are cleared by a pass over all PAIRS label pairs
// (256 with the present sizes), during which in_ready_o stays low.
// ----------------------------------------------------------------------------
module sorted_frame_count_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sfct_pkg::IN_LBL_W-1:0] parent_label_i,
  input  logic [sfct_pkg::IN_LBL_W-1:0] head_label_i,
  input  logic [sfct_pkg::CODE_W-1:0]  left_frame_i,
  input  logic [sfct_pkg::CODE_W-1:0]  right_frame_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sfct_pkg::CNT_W-1:0]   left_count_o,
  output logic [sfct_pkg::OUT_POS_W-1:0] left_position_o,
  output logic                         left_inserted_o,
  output logic [sfct_pkg::CNT_W-1:0]   right_count_o,
  output logic [sfct_pkg::OUT_POS_W-1:0] right_position_o,
  output logic                         right_inserted_o,
  output logic                         list_full_o
);

  localparam int unsigned POS_W  = sfct_pkg::POS_W;
  localparam int unsigned LEN_W  = sfct_pkg::LEN_W;
  localparam int unsigned PAIR_W = sfct_pkg::PAIR_W;
  localparam int unsigned CNT_W  = sfct_pkg::CNT_W;
  localparam int unsigned CODE_W = sfct_pkg::CODE_W;

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SETUP = 4'd2;
  localparam logic [3:0] ST_SCAN  = 4'd3;
  localparam logic [3:0] ST_INC   = 4'd4;
  localparam logic [3:0] ST_SHIFT = 4'd5;
  localparam logic [3:0] ST_INS   = 4'd6;
  localparam logic [3:0] ST_NEXT  = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(sfct_pkg::LIST_SLOTS);
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  logic [3:0]          state_q, state_d;
  logic                side_q, side_d;
  logic [PAIR_W-1:0]   pair_q;
  logic [CODE_W-1:0]   lcode_q, rcode_q;
  logic [LEN_W-1:0]    n_q, n_d;
  logic [LEN_W-1:0]    idx_q, idx_d;
  logic                pend_q, pend_d;
  logic [LEN_W-1:0]    pos_q, pos_d;
  logic [POS_W-1:0]    sh_q, sh_d;
  logic [POS_W-1:0]    wslot_q, wslot_d;
  logic [LEN_W-1:0]    rem_q, rem_d;
  logic [PAIR_W-1:0]   clr_q, clr_d;
  logic                full_q, full_d;

  // Per-side results of the current item.
  logic [CNT_W-1:0]    res_cnt_q [2];
  logic [LEN_W-1:0]    res_pos_q [2];
  logic                res_ins_q [2];
  logic                res_ld;
  logic [CNT_W-1:0]    res_cnt;
  logic [LEN_W-1:0]    res_pos;
  logic                res_ins;

  logic                out_valid_q;
  logic                out_ld;
  logic                in_acc;

  // Memory controls.
  logic                ent_re, ent_we;
  logic [POS_W-1:0]    ent_rslot, ent_wslot;
  sfct_pkg::entry_t    ent_wdata;
  sfct_pkg::entry_t    ent_rd_l, ent_rd_r, ent_rd;
  logic                len_re, len_we_l, len_we_r;
  logic [PAIR_W-1:0]   len_raddr, len_waddr;
  logic [LEN_W-1:0]    len_wdata;
  logic [LEN_W-1:0]    len_rd_l, len_rd_r;

  // Shared compare and increment unit.
  logic [CODE_W-1:0]   code_sel;
  logic                code_lt, code_eq;
  logic [CNT_W-1:0]    inc_cnt;
  logic [LEN_W-1:0]    hit_pos;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign code_sel   = side_q ? rcode_q : lcode_q;
  assign ent_rd     = side_q ? ent_rd_r : ent_rd_l;
  assign code_lt    = (ent_rd.code < code_sel);
  assign code_eq    = (ent_rd.code == code_sel);
  assign inc_cnt    = (ent_rd.count == CNT_MAX) ? CNT_MAX : ent_rd.count + CNT_W'(1);
  assign hit_pos    = idx_q - LEN_W'(1);
  assign len_raddr  = sfct_pkg::pair_index(sfct_pkg::reduce_label(parent_label_i),
                                           sfct_pkg::reduce_label(head_label_i));

  // Sequencer next-state and memory control logic.
  always_comb begin
    state_d   = state_q;
    side_d    = side_q;
    n_d       = n_q;
    idx_d     = idx_q;
    pend_d    = pend_q;
    pos_d     = pos_q;
    sh_d      = sh_q;
    wslot_d   = wslot_q;
    rem_d     = rem_q;
    clr_d     = clr_q;
    full_d    = full_q;
    res_ld    = 1'b0;
    res_cnt   = '0;
    res_pos   = pos_q;
    res_ins   = 1'b0;
    out_ld    = 1'b0;
    ent_re    = 1'b0;
    ent_we    = 1'b0;
    ent_rslot = idx_q[POS_W-1:0];
    ent_wslot = pos_q[POS_W-1:0];
    ent_wdata = ent_rd;
    len_re    = 1'b0;
    len_we_l  = 1'b0;
    len_we_r  = 1'b0;
    len_waddr = pair_q;
    len_wdata = n_q + LEN_W'(1);

    case (state_q)
      ST_CLEAR: begin
        len_we_l  = 1'b1;
        len_we_r  = 1'b1;
        len_waddr = clr_q;
        len_wdata = '0;
        clr_d     = clr_q + PAIR_W'(1);
        if (clr_q == PAIR_W'(sfct_pkg::PAIRS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          len_re  = 1'b1;
          side_d  = 1'b0;
          full_d  = 1'b0;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        n_d     = side_q ? len_rd_r : len_rd_l;
        idx_d   = '0;
        pend_d  = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if ((pend_q && !code_lt) || (!pend_q || code_lt) && (idx_q == n_q)) begin
          // The scan has stopped: either at a code not below the new one or
          // past the end of the list.
          pos_d  = (pend_q && !code_lt) ? hit_pos : n_q;
          pend_d = 1'b0;
          if (pend_q && code_eq) begin
            state_d = ST_INC;
          end else if (n_q == FULL_LEN) begin
            res_ld  = 1'b1;
            res_cnt = '0;
            res_pos = n_q;
            res_ins = 1'b0;
            full_d  = 1'b1;
            state_d = ST_NEXT;
          end else begin
            rem_d   = n_q - ((pend_q && !code_lt) ? hit_pos : n_q);
            sh_d    = POS_W'(n_q - LEN_W'(1));
            state_d = ST_SHIFT;
          end
        end else begin
          ent_re    = 1'b1;
          ent_rslot = idx_q[POS_W-1:0];
          idx_d     = idx_q + LEN_W'(1);
          pend_d    = 1'b1;
        end
      end
      ST_INC: begin
        ent_we          = 1'b1;
        ent_wslot       = pos_q[POS_W-1:0];
        ent_wdata.code  = code_sel;
        ent_wdata.count = inc_cnt;
        res_ld          = 1'b1;
        res_cnt         = inc_cnt;
        res_ins         = 1'b0;
        state_d         = ST_NEXT;
      end
      ST_SHIFT: begin
        // Move the later entries up one slot, from the top downwards.
        if (pend_q) begin
          ent_we    = 1'b1;
          ent_wslot = wslot_q;
          ent_wdata = ent_rd;
        end
        if (rem_q != '0) begin
          ent_re    = 1'b1;
          ent_rslot = sh_q;
          wslot_d   = sh_q + POS_W'(1);
          sh_d      = sh_q - POS_W'(1);
          rem_d     = rem_q - LEN_W'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        ent_we          = 1'b1;
        ent_wslot       = pos_q[POS_W-1:0];
        ent_wdata.code  = code_sel;
        ent_wdata.count = CNT_W'(1);
        len_we_l        = !side_q;
        len_we_r        = side_q;
        res_ld          = 1'b1;
        res_cnt         = CNT_W'(1);
        res_ins         = 1'b1;
        state_d         = ST_NEXT;
      end
      ST_NEXT: begin
        if (!side_q) begin
          side_d  = 1'b1;
          state_d = ST_SETUP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      side_q      <= 1'b0;
      pend_q      <= 1'b0;
      clr_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      rem_q       <= '0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
      full_q  <= full_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      rem_q   <= rem_d;
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Low bits of a slot number as reported on the output.
  function automatic logic [sfct_pkg::OUT_POS_W-1:0] OUT_POS_W_CAST(logic [LEN_W-1:0] p);
    return sfct_pkg::OUT_POS_W'(p);
  endfunction

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    sh_q    <= sh_d;
    wslot_q <= wslot_d;
    if (in_acc) begin
      pair_q  <= len_raddr;
      lcode_q <= left_frame_i;
      rcode_q <= right_frame_i;
    end
    if (res_ld) begin
      res_cnt_q[side_q] <= res_cnt;
      res_pos_q[side_q] <= res_pos;
      res_ins_q[side_q] <= res_ins;
    end
    if (out_ld) begin
      left_count_o     <= res_cnt_q[0];
      left_position_o  <= OUT_POS_W_CAST(res_pos_q[0]);
      left_inserted_o  <= res_ins_q[0];
      right_count_o    <= res_cnt_q[1];
      right_position_o <= OUT_POS_W_CAST(res_pos_q[1]);
      right_inserted_o <= res_ins_q[1];
      list_full_o      <= full_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Entry memories, one per side.
  sfct_ram #(
    .WIDTH(sfct_pkg::ENTRY_W),
    .DEPTH(sfct_pkg::ENTRIES)
  ) u_left_entries (
    .clk_i  (clk_i),
    .we_i   (ent_we && !side_q),
    .waddr_i(sfct_pkg::entry_addr(pair_q, ent_wslot)),
    .wdata_i(ent_wdata),
    .re_i   (ent_re && !side_q),
    .raddr_i(sfct_pkg::entry_addr(pair_q, ent_rslot)),
    .rdata_o(ent_rd_l)
  );

  sfct_ram #(
    .WIDTH(sfct_pkg::ENTRY_W),
    .DEPTH(sfct_pkg::ENTRIES)
  ) u_right_entries (
    .clk_i  (clk_i),
    .we_i   (ent_we && side_q),
    .waddr_i(sfct_pkg::entry_addr(pair_q, ent_wslot)),
    .wdata_i(ent_wdata),
    .re_i   (ent_re && side_q),
    .raddr_i(sfct_pkg::entry_addr(pair_q, ent_rslot)),
    .rdata_o(ent_rd_r)
  );

  // List length memories, one per side.
  sfct_ram #(
    .WIDTH(LEN_W),
    .DEPTH(sfct_pkg::PAIRS)
  ) u_left_lengths (
    .clk_i  (clk_i),
    .we_i   (len_we_l),
    .waddr_i(len_waddr),
    .wdata_i(len_wdata),
    .re_i   (len_re),
    .raddr_i(len_raddr),
    .rdata_o(len_rd_l)
  );

  sfct_ram #(
    .WIDTH(LEN_W),
    .DEPTH(sfct_pkg::PAIRS)
  ) u_right_lengths (
    .clk_i  (clk_i),
    .we_i   (len_we_r),
    .waddr_i(len_waddr),
    .wdata_i(len_wdata),
    .re_i   (len_re),
    .raddr_i(len_raddr),
    .rdata_o(len_rd_r)
  );

`ifndef SYNTHESIS
  // A newly inserted code always reports a count of one.
  a_left_ins_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && left_inserted_o |-> left_count_o == CNT_W'(1))
    else $error("left insertion with count other than one");

  a_right_ins_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && right_inserted_o |-> right_count_o == CNT_W'(1))
    else $error("right insertion with count other than one");

  // A refused insertion leaves at least one side with a zero count.
  a_full_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && list_full_o |->
      (left_count_o == '0 && !left_inserted_o) ||
      (right_count_o == '0 && !right_inserted_o))
    else $error("full flag without a refused side");

  // The scan never runs past the list length.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> n_q <= FULL_LEN && idx_q <= n_q)
    else $error("scan index beyond list length");

  // Entries are never moved within a full list.
  a_no_shift_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SHIFT && rem_q != '0 |-> n_q < FULL_LEN)
    else $error("entry move on a full list");
`endif

endmodule
